// ===== rtl/hbef_pkg.sv =====
// types and constants shared by the harmonic bond energy and force pipeline
package hbef_pkg;

  localparam int unsigned PosW    = 32;
  localparam int unsigned RegW    = 32;
  localparam int unsigned DiffW   = 33;
  localparam int unsigned SqW     = 66;
  localparam int unsigned RootW   = 35;
  localparam int unsigned RemW    = 72;
  localparam int unsigned DmW     = 35;
  localparam int unsigned KdW     = 67;
  localparam int unsigned KdLoW   = 34;
  localparam int unsigned KdHiW   = KdW - KdLoW;
  localparam int unsigned ProdW   = 101;
  localparam int unsigned NumW    = 100;
  localparam int unsigned QBits   = 39;
  localparam int unsigned EnergyW = 48;
  localparam int unsigned PushW   = 40;

  typedef logic signed [PosW-1:0]    pos_t;
  typedef logic        [RegW-1:0]    reg_t;
  typedef logic        [EnergyW-1:0] energy_t;
  typedef logic signed [PushW-1:0]   push_t;

  typedef enum logic [1:0] {
    CfgStiffA = 2'd0,
    CfgStiffB = 2'd1,
    CfgRestA  = 2'd2,
    CfgRestB  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0][DiffW-1:0] mag;
    logic [2:0]            dneg;
    logic [1:0]            species;
  } side_t;

endpackage

// ===== rtl/harmonic_bond_energy_force.sv =====
// harmonic bond energy and force pipeline, top level
//
// one bond word is taken in every cycle; busy_o is always low. each result
// word appears on done_o once it has passed the pipeline: 3 input and
// squaring stages, 35 square root stages (one root bit each), 5 stages
// of multiply and setup, 39 divider stages (one quotient bit each) and
// the output register. a result is shown for one cycle only and cannot be
// held off by the receiver. write the configuration only while no word is
// in flight; later words then use the new values.
module harmonic_bond_energy_force #(
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  hbef_pkg::pos_t     first_x_i,
  input  hbef_pkg::pos_t     first_y_i,
  input  hbef_pkg::pos_t     first_z_i,
  input  hbef_pkg::pos_t     second_x_i,
  input  hbef_pkg::pos_t     second_y_i,
  input  hbef_pkg::pos_t     second_z_i,
  input  logic               first_species_i,
  input  logic               second_species_i,
  output logic               done_o,
  output hbef_pkg::energy_t  bond_energy_o,
  output hbef_pkg::push_t    push_x_o,
  output hbef_pkg::push_t    push_y_o,
  output hbef_pkg::push_t    push_z_o,
  output logic               zero_distance_o,
  input  logic               cfg_we_i,
  input  hbef_pkg::cfg_idx_e cfg_idx_i,
  input  hbef_pkg::reg_t     cfg_wdata_i
);
  import hbef_pkg::*;

  localparam int unsigned DivW   = RootW + FracBits;
  localparam int unsigned ShiftE = 2 * FracBits + 1;
  localparam int unsigned NumSt  = 3 + RootW + 5 + QBits + 1;

  typedef struct packed {
    logic [DivW-1:0] dvs;
    energy_t         energy;
    logic [2:0]      over;
    logic [2:0]      neg;
    logic            zero;
  } dside_t;

  // configuration registers
  reg_t stiff_a_q, stiff_b_q, rest_a_q, rest_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_a_q <= RegW'(1) << FracBits;
      stiff_b_q <= RegW'(1) << FracBits;
      rest_a_q  <= RegW'(1) << FracBits;
      rest_b_q  <= RegW'(1) << FracBits;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStiffA: stiff_a_q <= cfg_wdata_i;
        CfgStiffB: stiff_b_q <= cfg_wdata_i;
        CfgRestA:  rest_a_q  <= cfg_wdata_i;
        CfgRestB:  rest_b_q  <= cfg_wdata_i;
        default:   stiff_a_q <= stiff_a_q;
      endcase
    end
  end

  // valid bits
  logic [NumSt-1:0] vld_q, vld_d;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[NumSt-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[NumSt-1];

  // stage 1: differences and mixed stiffness product
  logic signed [DiffW-1:0] d1_q [3];
  logic [1:0]              sp1_q;
  logic [2*RegW-1:0]       kk1_q;

  always_ff @(posedge clk_i) begin
    d1_q[0] <= DiffW'(first_x_i) - DiffW'(second_x_i);
    d1_q[1] <= DiffW'(first_y_i) - DiffW'(second_y_i);
    d1_q[2] <= DiffW'(first_z_i) - DiffW'(second_z_i);
    sp1_q   <= {first_species_i, second_species_i};
    kk1_q   <= (2*RegW)'(stiff_a_q) * (2*RegW)'(stiff_b_q);
  end

  // stage 2: magnitudes and squares
  side_t             side2_q;
  logic [SqW-1:0]    sq2_q [3];
  logic [2*RegW-1:0] kk2_q;
  logic [DiffW-1:0]  mag1 [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag1[a] = d1_q[a][DiffW-1] ? DiffW'(-d1_q[a]) : DiffW'(d1_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      side2_q.mag[a]  <= mag1[a];
      side2_q.dneg[a] <= d1_q[a][DiffW-1];
      sq2_q[a]        <= SqW'(mag1[a]) * SqW'(mag1[a]);
    end
    side2_q.species <= sp1_q;
    kk2_q           <= kk1_q;
  end

  // stage 3: sum of squares
  side_t             side3_q;
  logic [SqW-1:0]    s3_q;
  logic [2*RegW-1:0] kk3_q;

  always_ff @(posedge clk_i) begin
    side3_q <= side2_q;
    s3_q    <= sq2_q[0] + sq2_q[1] + sq2_q[2];
    kk3_q   <= kk2_q;
  end

  // square root stages, distance and mixed stiffness side by side
  logic [RemW-1:0]  rem_q   [RootW];
  logic [RootW-1:0] root_q  [RootW];
  logic [RemW-1:0]  krem_q  [RootW];
  logic [RootW-1:0] kroot_q [RootW];
  side_t            side_q  [RootW];

  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    localparam int unsigned Bit = RootW - 1 - j;
    logic [RemW-1:0]  rem_in, krem_in, trial, ktrial;
    logic [RootW-1:0] root_in, kroot_in;
    side_t            side_in;

    if (j == 0) begin : g_first
      assign rem_in   = RemW'(s3_q);
      assign krem_in  = RemW'(kk3_q);
      assign root_in  = '0;
      assign kroot_in = '0;
      assign side_in  = side3_q;
    end else begin : g_next
      assign rem_in   = rem_q[j-1];
      assign krem_in  = krem_q[j-1];
      assign root_in  = root_q[j-1];
      assign kroot_in = kroot_q[j-1];
      assign side_in  = side_q[j-1];
    end

    assign trial  = (RemW'(root_in) << (Bit + 1)) + (RemW'(1) << (2 * Bit));
    assign ktrial = (RemW'(kroot_in) << (Bit + 1)) + (RemW'(1) << (2 * Bit));

    always_ff @(posedge clk_i) begin
      if (rem_in >= trial) begin
        rem_q[j]  <= rem_in - trial;
        root_q[j] <= root_in | (RootW'(1) << Bit);
      end else begin
        rem_q[j]  <= rem_in;
        root_q[j] <= root_in;
      end
      if (krem_in >= ktrial) begin
        krem_q[j]  <= krem_in - ktrial;
        kroot_q[j] <= kroot_in | (RootW'(1) << Bit);
      end else begin
        krem_q[j]  <= krem_in;
        kroot_q[j] <= kroot_in;
      end
      side_q[j] <= side_in;
    end
  end

  // stage: pair constants, stretch and its sign
  logic [RootW-1:0]        r_s;
  side_t                   sd_s;
  reg_t                    k_s, l_s;
  logic signed [RootW:0]   delta_s;
  logic [DmW-1:0]          dm_s;
  logic [2:0]              neg_s;

  assign r_s  = root_q[RootW-1];
  assign sd_s = side_q[RootW-1];

  always_comb begin
    case (sd_s.species)
      2'b00: begin
        k_s = stiff_a_q;
        l_s = rest_a_q;
      end
      2'b11: begin
        k_s = stiff_b_q;
        l_s = rest_b_q;
      end
      default: begin
        k_s = kroot_q[RootW-1][RegW-1:0];
        l_s = RegW'(((RegW+1)'(rest_a_q) + (RegW+1)'(rest_b_q)) >> 1);
      end
    endcase
    delta_s = $signed({1'b0, r_s}) - $signed((RootW+1)'(l_s));
    dm_s    = delta_s[RootW] ? DmW'(-delta_s) : DmW'(delta_s);
    for (int a = 0; a < 3; a++) begin
      neg_s[a] = sd_s.dneg[a] ? delta_s[RootW] : (!delta_s[RootW] && delta_s != '0);
    end
  end

  reg_t                   k39_q;
  logic [DmW-1:0]         dm39_q, dm40_q;
  logic [RootW-1:0]       r39_q, r40_q, r41_q, r42_q;
  logic [2:0]             neg39_q, neg40_q, neg41_q, neg42_q;
  logic                   zero39_q, zero40_q, zero41_q, zero42_q;
  logic [2:0][DiffW-1:0]  m39_q, m40_q;
  logic [KdW-1:0]         kd40_q;

  always_ff @(posedge clk_i) begin
    k39_q    <= k_s;
    dm39_q   <= dm_s;
    r39_q    <= r_s;
    neg39_q  <= neg_s;
    zero39_q <= (r_s == '0);
    m39_q    <= sd_s.mag;
  end

  // stage: stiffness times stretch
  always_ff @(posedge clk_i) begin
    kd40_q   <= KdW'(k39_q) * KdW'(dm39_q);
    dm40_q   <= dm39_q;
    r40_q    <= r39_q;
    neg40_q  <= neg39_q;
    zero40_q <= zero39_q;
    m40_q    <= m39_q;
  end

  // stage: partial products
  logic [KdLoW+DmW-1:0]   pe_lo41_q;
  logic [KdHiW+DmW-1:0]   pe_hi41_q;
  logic [KdLoW+DiffW-1:0] pf_lo41_q [3];
  logic [KdHiW+DiffW-1:0] pf_hi41_q [3];
  logic [KdLoW-1:0]       kd_lo;
  logic [KdHiW-1:0]       kd_hi;

  assign kd_lo = kd40_q[KdLoW-1:0];
  assign kd_hi = kd40_q[KdW-1:KdLoW];

  always_ff @(posedge clk_i) begin
    pe_lo41_q <= (KdLoW+DmW)'(kd_lo) * (KdLoW+DmW)'(dm40_q);
    pe_hi41_q <= (KdHiW+DmW)'(kd_hi) * (KdHiW+DmW)'(dm40_q);
    for (int a = 0; a < 3; a++) begin
      pf_lo41_q[a] <= (KdLoW+DiffW)'(kd_lo) * (KdLoW+DiffW)'(m40_q[a]);
      pf_hi41_q[a] <= (KdHiW+DiffW)'(kd_hi) * (KdHiW+DiffW)'(m40_q[a]);
    end
    r41_q    <= r40_q;
    neg41_q  <= neg40_q;
    zero41_q <= zero40_q;
  end

  // stage: combine partial products
  logic [ProdW-1:0] e42_q;
  logic [NumW-1:0]  n42_q [3];

  always_ff @(posedge clk_i) begin
    e42_q <= ProdW'(pe_lo41_q) + (ProdW'(pe_hi41_q) << KdLoW);
    for (int a = 0; a < 3; a++) begin
      n42_q[a] <= NumW'(pf_lo41_q[a]) + (NumW'(pf_hi41_q[a]) << KdLoW);
    end
    r42_q    <= r41_q;
    neg42_q  <= neg41_q;
    zero42_q <= zero41_q;
  end

  // stage: energy saturation and divider setup
  logic [ProdW-1:0] e_sh;
  logic [DivW-1:0]  dvs_s;
  logic [NumW-1:0]  dvs_top;
  dside_t           ds43_q;
  logic [NumW-1:0]  n43_q [3];

  assign e_sh    = e42_q >> ShiftE;
  assign dvs_s   = DivW'(r42_q) << FracBits;
  assign dvs_top = NumW'(dvs_s) << QBits;

  always_ff @(posedge clk_i) begin
    ds43_q.energy <= (|e_sh[ProdW-1:EnergyW]) ? '1 : e_sh[EnergyW-1:0];
    ds43_q.dvs    <= dvs_s;
    ds43_q.neg    <= neg42_q;
    ds43_q.zero   <= zero42_q;
    for (int a = 0; a < 3; a++) begin
      ds43_q.over[a] <= (n42_q[a] >= dvs_top);
      n43_q[a]       <= n42_q[a];
    end
  end

  // divider stages, one quotient bit each
  logic [NumW-1:0]  drem_q [QBits][3];
  logic [QBits-1:0] dq_q   [QBits][3];
  dside_t           dside_q [QBits];

  for (genvar j = 0; j < QBits; j++) begin : g_div
    localparam int unsigned Bit = QBits - 1 - j;
    logic [NumW-1:0]  rem_in [3];
    logic [QBits-1:0] q_in   [3];
    dside_t           side_in;
    logic [NumW-1:0]  dsub;

    if (j == 0) begin : g_first
      assign side_in = ds43_q;
      for (genvar a = 0; a < 3; a++) begin : g_ax
        assign rem_in[a] = n43_q[a];
        assign q_in[a]   = '0;
      end
    end else begin : g_next
      assign side_in = dside_q[j-1];
      for (genvar a = 0; a < 3; a++) begin : g_ax
        assign rem_in[a] = drem_q[j-1][a];
        assign q_in[a]   = dq_q[j-1][a];
      end
    end

    assign dsub = NumW'(side_in.dvs) << Bit;

    always_ff @(posedge clk_i) begin
      for (int a = 0; a < 3; a++) begin
        if (rem_in[a] >= dsub) begin
          drem_q[j][a] <= rem_in[a] - dsub;
          dq_q[j][a]   <= q_in[a] | (QBits'(1) << Bit);
        end else begin
          drem_q[j][a] <= rem_in[a];
          dq_q[j][a]   <= q_in[a];
        end
      end
      dside_q[j] <= side_in;
    end
  end

  // output stage: sign, saturation and zero distance
  dside_t           dl;
  logic [PushW-1:0] mag_o [3];
  logic [PushW-1:0] push_s [3];

  assign dl = dside_q[QBits-1];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag_o[a] = dl.over[a] ? (PushW'(1) << (PushW - 1)) : PushW'(dq_q[QBits-1][a]);
      if (dl.zero) begin
        push_s[a] = '0;
      end else if (dl.neg[a]) begin
        push_s[a] = -mag_o[a];
      end else if (dl.over[a]) begin
        push_s[a] = {1'b0, {(PushW-1){1'b1}}};
      end else begin
        push_s[a] = mag_o[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bond_energy_o   <= dl.energy;
    push_x_o        <= push_s[0];
    push_y_o        <= push_s[1];
    push_z_o        <= push_s[2];
    zero_distance_o <= dl.zero;
  end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the harmonic bond energy and force pipeline
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hbef_pkg::*;

  localparam int unsigned Frac      = 16;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned PerPhase  = 75;
  localparam int unsigned WdogLimit = 3000;
  localparam longint unsigned Pos40 = 64'h7F_FFFF_FFFF;
  localparam longint unsigned Neg40 = 64'h80_0000_0000;
  localparam longint unsigned Max48 = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    energy_t energy;
    push_t   px;
    push_t   py;
    push_t   pz;
    logic    zero_dist;
  } bond_res_t;

  typedef struct packed {
    pos_t      fx, fy, fz, sx, sy, sz;
    logic      fs, ss;
    logic      known;
    bond_res_t res;
  } bond_row_t;

  logic      clk_i, rst_ni;
  logic      start_i, busy_o, done_o, zero_distance_o;
  pos_t      first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i;
  logic      first_species_i, second_species_i;
  energy_t   bond_energy_o;
  push_t     push_x_o, push_y_o, push_z_o;
  logic      cfg_we_i;
  cfg_idx_e  cfg_idx_i;
  reg_t      cfg_wdata_i;

  reg_t      k_a, k_b, len_a, len_b;
  bond_res_t bond_expect_q[$];
  bond_row_t bond_rows[$];
  int        mismatches;
  int        idle_cycles;

  harmonic_bond_energy_force i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned root_floor(bit [127:0] a);
    longint unsigned c, t;
    c = 0;
    for (int b = 34; b >= 0; b--) begin
      t = c | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= a) c = t;
    end
    return c;
  endfunction

  function automatic bond_res_t bond_predict(bond_row_t w);
    longint    d[3];
    longint    mag[3];
    bit [127:0] sq, kd, num, den, q;
    longint unsigned r, k, l, dm;
    longint    delta;
    bond_res_t res;
    d[0] = longint'(w.fx) - longint'(w.sx);
    d[1] = longint'(w.fy) - longint'(w.sy);
    d[2] = longint'(w.fz) - longint'(w.sz);
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      sq += 128'(mag[i]) * 128'(mag[i]);
    end
    r = root_floor(sq);
    if (!w.fs && !w.ss) begin
      k = k_a; l = len_a;
    end else if (w.fs && w.ss) begin
      k = k_b; l = len_b;
    end else begin
      k = root_floor(128'(64'(k_a) * 64'(k_b)));
      l = (64'(len_a) + 64'(len_b)) >> 1;
    end
    delta = longint'(r) - longint'(l);
    dm = delta < 0 ? -delta : delta;
    kd = 128'(k) * 128'(dm);
    q = (kd * 128'(dm)) >> (2 * Frac + 1);
    res.energy = q > 128'(Max48) ? Max48[47:0] : q[47:0];
    for (int i = 0; i < 3; i++) begin
      push_t f;
      f = '0;
      if (r != 0) begin
        num = kd * 128'(mag[i]);
        den = 128'(r) << Frac;
        q = num / den;
        if ((delta > 0 && d[i] > 0) || (delta < 0 && d[i] < 0)) begin
          if (q > 128'(Neg40)) q = 128'(Neg40);
          f = -q[39:0];
        end else begin
          if (q > 128'(Pos40)) q = 128'(Pos40);
          f = q[39:0];
        end
      end
      if (i == 0) res.px = f;
      else if (i == 1) res.py = f;
      else res.pz = f;
    end
    res.zero_dist = (r == 0);
    return res;
  endfunction

  task automatic add_row(pos_t fx, pos_t fy, pos_t fz, pos_t sx, pos_t sy, pos_t sz,
                         logic fs, logic ss, logic known, bond_res_t res);
    bond_row_t w;
    w = '{fx, fy, fz, sx, sy, sz, fs, ss, known, res};
    bond_rows.push_back(w);
  endtask

  task automatic cfg_write(cfg_idx_e idx, reg_t val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgStiffA: k_a = val;
      CfgStiffB: k_b = val;
      CfgRestA:  len_a = val;
      default:   len_b = val;
    endcase
  endtask

  task automatic send_bond(bond_row_t w);
    @(negedge clk_i);
    start_i <= 1'b1;
    first_x_i <= w.fx; first_y_i <= w.fy; first_z_i <= w.fz;
    second_x_i <= w.sx; second_y_i <= w.sy; second_z_i <= w.sz;
    first_species_i <= w.fs; second_species_i <= w.ss;
    do @(posedge clk_i); while (busy_o);
    bond_expect_q.push_back(w.known ? w.res : bond_predict(w));
  endtask

  task automatic pause_sender(int n);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain;
    pause_sender(1);
    wait (bond_expect_q.size() == 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic bond_row_t random_bond();
    bond_row_t w;
    w = '0;
    w.fs = $urandom_range(0, 1);
    w.ss = $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 6) begin
      w.sx = $signed($urandom_range(0, 20 << Frac)) - (10 << Frac);
      w.sy = $signed($urandom_range(0, 20 << Frac)) - (10 << Frac);
      w.sz = $signed($urandom_range(0, 20 << Frac)) - (10 << Frac);
      w.fx = w.sx + $signed($urandom_range(0, 6 << Frac)) - (3 << Frac);
      w.fy = w.sy + $signed($urandom_range(0, 6 << Frac)) - (3 << Frac);
      w.fz = w.sz + $signed($urandom_range(0, 6 << Frac)) - (3 << Frac);
      if ($urandom_range(0, 15) == 0) {w.fx, w.fy, w.fz} = {w.sx, w.sy, w.sz};
    end else begin
      {w.fx, w.fy, w.fz} = {$urandom, $urandom, $urandom};
      {w.sx, w.sy, w.sz} = {$urandom, $urandom, $urandom};
    end
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (done_o) begin
      if (bond_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word");
      end else begin
        bond_res_t exp_res, got;
        exp_res = bond_expect_q.pop_front();
        got = '{bond_energy_o, push_x_o, push_y_o, push_z_o, zero_distance_o};
        if (got !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp e=%h x=%h y=%h z=%h zd=%b got e=%h x=%h y=%h z=%h zd=%b",
                     exp_res.energy, exp_res.px, exp_res.py, exp_res.pz, exp_res.zero_dist,
                     got.energy, got.px, got.py, got.pz, got.zero_dist);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    bond_res_t half, none;
    int total;
    mismatches = 0; idle_cycles = 0;
    rst_ni = 1'b0; start_i = 1'b0; cfg_we_i = 1'b0;
    cfg_idx_i = CfgStiffA; cfg_wdata_i = '0;
    {first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i} = '0;
    first_species_i = 1'b0; second_species_i = 1'b0;
    k_a = 1 << Frac; k_b = 1 << Frac; len_a = 1 << Frac; len_b = 1 << Frac;
    half = '{48'd32768, '0, '0, '0, 1'b1};
    none = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // coincident atoms and a bond exactly at rest length
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, half);
    add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 1, 1, 1, half);
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 0, 1, 1, half);
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 1, half);
    add_row(1 << Frac, 0, 0, 0, 0, 0, 0, 0, 1, none);
    add_row(0, -(1 << Frac), 0, 0, 0, 0, 1, 1, 1, none);
    // extremes and saturation
    add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
            32'h80000000, 0, 0, 0, none);
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 1, 1, 0, none);
    add_row(32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 1, 0, none);
    add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 1, 0, 0, none);
    // compressed and stretched bonds on each axis
    add_row(2 << Frac, 0, 0, 0, 0, 0, 0, 1, 0, none);
    add_row(0, 3 << Frac, 0, 0, 0, 0, 0, 0, 0, none);
    add_row(0, 0, -(1 << (Frac - 1)), 0, 0, 0, 1, 1, 0, none);
    add_row(1, 1, 1, 0, 0, 0, 0, 0, 0, none);
    add_row(-5, 7 << Frac, 3, 2 << Frac, -(1 << Frac), 9, 1, 0, 0, none);
    add_row(32'h00012345, 32'hFFFE0000, 32'h0000ABCD, 32'hFFFF8000, 32'h00030000,
            32'h0, 0, 1, 0, none);
    foreach (bond_rows[i]) send_bond(bond_rows[i]);

    total = NumPhases * PerPhase;
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        1: begin
          cfg_write(CfgStiffA, $urandom_range(0, 4 << Frac));
          cfg_write(CfgStiffB, $urandom_range(0, 4 << Frac));
          cfg_write(CfgRestA, $urandom_range(0, 3 << Frac));
          cfg_write(CfgRestB, $urandom_range(0, 3 << Frac));
        end
        2: begin
          cfg_write(CfgStiffA, '1); cfg_write(CfgStiffB, '1);
          cfg_write(CfgRestA, '1);  cfg_write(CfgRestB, '1);
        end
        3: begin
          cfg_write(CfgStiffA, '0); cfg_write(CfgStiffB, '0);
          cfg_write(CfgRestA, '0);  cfg_write(CfgRestB, '0);
        end
        4: begin
          cfg_write(CfgStiffA, '1); cfg_write(CfgStiffB, '0);
          cfg_write(CfgRestA, '0);  cfg_write(CfgRestB, '1);
        end
        5: begin
          cfg_write(CfgStiffA, $urandom); cfg_write(CfgStiffB, $urandom);
          cfg_write(CfgRestA, $urandom);  cfg_write(CfgRestB, $urandom);
        end
        default: ;
      endcase
      for (int n = 0; n < PerPhase; n++) begin
        send_bond(random_bond());
        if (ph * PerPhase + n < total - 60 && $urandom_range(0, 3) == 0)
          pause_sender($urandom_range(1, 16));
      end
    end
    pause_sender(1);
    wait (bond_expect_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
